// ===== hdl/lbb_pkg.sv =====
// Package for the LED blink and burst controller.
// Holds the transfer payload types, command and mode codes and register indexes.
// No dependencies.
`default_nettype none

package lbb_pkg;

  // Width of all millisecond times and table entries.
  localparam int unsigned TimeW = 32;
  // Field widths fixed by the interface.
  localparam int unsigned IndexW = 4;
  localparam int unsigned LengthW = 5;

  // Command codes carried by an input transfer.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_START = 2'd2
  } cmd_e;

  // Base mode codes.
  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_BLINK = 2'd2
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_BASE_MODE = 2'd0,
    REG_ON_TIME   = 2'd1,
    REG_OFF_TIME  = 2'd2
  } reg_e;

  // One input item.
  typedef struct packed {
    logic [1:0]         command;
    logic [TimeW-1:0]   now_ms;
    logic [IndexW-1:0]  entry_index;
    logic [TimeW-1:0]   entry_value;
    logic [LengthW-1:0] burst_length;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic led;
    logic burst_active;
  } out_item_t;

  // Configuration register contents.
  typedef struct packed {
    logic [1:0]       base_mode;
    logic [TimeW-1:0] on_time_ms;
    logic [TimeW-1:0] off_time_ms;
  } cfg_t;

  // Controller state carried from one item to the next.
  typedef struct packed {
    logic               led_lit;
    logic [TimeW-1:0]   changed_at;
    logic [LengthW-1:0] burst_count;
    logic [LengthW-1:0] burst_position;
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/lbb_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// A read of the address being written returns the new data. No dependencies.
`default_nettype none

module lbb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, forwarding data written in the same cycle.
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/lbb_step.sv =====
// Next-state logic of the LED controller for one accepted item.
// Depends on lbb_pkg for the item, configuration and state types.
`default_nettype none

module lbb_step #(
  parameter int unsigned BURST_DEPTH = 16
) (
  input  lbb_pkg::in_item_t           item_i,
  input  lbb_pkg::cfg_t               cfg_i,
  input  lbb_pkg::state_t             state_i,
  input  wire logic [lbb_pkg::TimeW-1:0] entry_i,
  output lbb_pkg::state_t             state_o
);

  import lbb_pkg::*;

  logic [TimeW-1:0]   elapsed;
  logic [TimeW-1:0]   off_dur;
  logic               want;
  logic [LengthW-1:0] pos_next;

  // Wrapping elapsed time and the effective blink off time.
  assign elapsed = item_i.now_ms - state_i.changed_at;
  assign off_dur = (cfg_i.off_time_ms != '0) ? cfg_i.off_time_ms : cfg_i.on_time_ms;
  // Even positions are on times, odd positions are off times.
  assign want    = ~state_i.burst_position[0];

  always_comb begin
    state_o  = state_i;
    pos_next = state_i.burst_position;
    case (item_i.command)
      CMD_TICK: begin
        if (state_i.burst_count != '0) begin
          // Burst playback: first take up the wanted level, then time it out.
          if (state_i.led_lit != want) begin
            state_o.led_lit    = want;
            state_o.changed_at = item_i.now_ms;
          end else if (elapsed >= entry_i) begin
            state_o.led_lit    = ~want;
            state_o.changed_at = item_i.now_ms;
            pos_next           = state_i.burst_position + LengthW'(1);
          end
          state_o.burst_position = pos_next;
          if (pos_next >= state_i.burst_count) begin
            state_o.burst_count = '0;
          end
        end else begin
          // Base mode.
          case (cfg_i.base_mode)
            MODE_OFF: begin
              state_o.led_lit    = 1'b0;
              state_o.changed_at = item_i.now_ms;
            end
            MODE_ON: begin
              state_o.led_lit    = 1'b1;
              state_o.changed_at = item_i.now_ms;
            end
            MODE_BLINK: begin
              if (state_i.led_lit && (elapsed >= cfg_i.on_time_ms)) begin
                state_o.led_lit    = 1'b0;
                state_o.changed_at = item_i.now_ms;
              end else if (!state_i.led_lit && (elapsed >= off_dur)) begin
                state_o.led_lit    = 1'b1;
                state_o.changed_at = item_i.now_ms;
              end
            end
            default: begin
              // The unused mode holds the LED as it is.
            end
          endcase
        end
      end
      CMD_START: begin
        // Lengths beyond the table depth saturate; zero cancels a burst.
        if (32'(item_i.burst_length) > 32'(BURST_DEPTH)) begin
          state_o.burst_count = LengthW'(BURST_DEPTH);
        end else begin
          state_o.burst_count = item_i.burst_length;
        end
        state_o.burst_position = '0;
      end
      default: begin
        // Table writes are handled by the RAM; the unused command does nothing.
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/led_blink_burst_controller.sv =====
// LED blink and burst controller. The result of an item is presented in the cycle after
// its transfer, from the output register. Throughput: one item per cycle, limited
// only by the output register; the table read for the next tick is registered in the RAM.
// Reset (asynchronous, active low) clears the LED state, burst state and configuration;
// the burst table is not cleared and must be written before it is played.
// Depends on lbb_pkg, lbb_ram and lbb_step.
`default_nettype none

module led_blink_burst_controller #(
  parameter int unsigned BURST_DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration write channel.
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  // Input item channel.
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  lbb_pkg::in_item_t       in_data_i,
  // Result channel.
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output lbb_pkg::out_item_t      out_data_o
);

  import lbb_pkg::*;

  localparam int unsigned AddrW = $clog2(BURST_DEPTH);

  cfg_t             cfg_q;
  state_t           state_q, state_d, step_state;
  logic             out_valid_q;
  out_item_t        out_data_q;
  logic             in_fire;
  logic             tbl_we;
  logic [TimeW-1:0] tbl_rdata;

  // Configuration registers, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BASE_MODE: cfg_q.base_mode   <= cfg_data_i[1:0];
        REG_ON_TIME:   cfg_q.on_time_ms  <= cfg_data_i;
        REG_OFF_TIME:  cfg_q.off_time_ms <= cfg_data_i;
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

  // An item is taken whenever the output register is free or being emptied.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Burst table writes for in-range indexes.
  assign tbl_we = in_fire && (in_data_i.command == CMD_WRITE) &&
                  (32'(in_data_i.entry_index) < 32'(BURST_DEPTH));

  // The read address follows the next position, so the entry is ready for the next tick.
  lbb_ram #(
    .WIDTH (TimeW),
    .DEPTH (BURST_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (AddrW'(in_data_i.entry_index)),
    .wdata_i (in_data_i.entry_value),
    .raddr_i (AddrW'(state_d.burst_position)),
    .rdata_o (tbl_rdata)
  );

  lbb_step #(
    .BURST_DEPTH (BURST_DEPTH)
  ) u_step (
    .item_i  (in_data_i),
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .entry_i (tbl_rdata),
    .state_o (step_state)
  );

  assign state_d = in_fire ? step_state : state_q;

  // Controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_fire;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q.led          <= step_state.led_lit;
      out_data_q.burst_active <= (step_state.burst_count != '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The burst length never exceeds the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(state_q.burst_count) <= 32'(BURST_DEPTH))
    else $error("burst count exceeds table depth");

  // While a burst plays, the position stays below its length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.burst_count != '0) |-> (state_q.burst_position < state_q.burst_count))
    else $error("burst position has run past the burst length");

  // A start with zero length leaves no burst running and reports it so.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.command == CMD_START) && (in_data_i.burst_length == '0))
    |=> (state_q.burst_count == '0) && out_valid_o && !out_data_o.burst_active)
    else $error("zero-length start did not cancel the burst");

endmodule

`default_nettype wire
